// ----- hdl/rc4_pkg.sv -----
// Shared types and constants for the RC4 byte cipher.
package rc4_pkg;

	localparam int KEY_DEPTH = 256;
	localparam int KEY_AW    = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
	localparam int KLEN_W    = 9;
	localparam logic [KLEN_W-1:0] KLEN_RESET = KLEN_W'(16);

	localparam logic [1:0] ACT_LOAD  = 2'd0;
	localparam logic [1:0] ACT_SCHED = 2'd1;
	localparam logic [1:0] ACT_CRYPT = 2'd2;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] key_index;
		logic [7:0] byte_value;
	} rc4_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [7:0] keystream_byte;
	} rc4_out_t;

endpackage

// ----- hdl/rc4_stream_cipher_top.sv -----
// RC4 byte cipher: key store, key schedule and keystream sequencer over one table RAM.
//
// Input channel src_*: one item per transfer. A load item writes byte_value into the
// key store at key_index (ignored past the key store depth) and leaves the block idle.
// A schedule item fills the permutation table with identity, mixes it with the key
// (two reads and two swap writes per entry) and clears both indices. A crypt item
// gives one result on res_*; the block is back in idle when the result appears.
// The steps come from the single-port table RAM, which serves one read or one write
// a cycle: two dependent reads, two writes of the swap and the keystream read.
// Action code 3 is dropped. src_stall is high while an item is at work.
// The key length register is written through cfg_we/cfg_wdata; the user must write it
// only while the block is idle, which the block does not enforce. 0 acts as 1 and values
// above the key store depth act as the depth.
// A finished result sits in the output register while res_stall is high; further
// items are accepted meanwhile, but a second crypt result waits in its last step
// until the register frees up. Reset clears the indices, the sequencer, the result
// valid flag and sets the key length to 16; the table is undefined until scheduled.
module rc4_stream_cipher_top (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   src_valid,
	output logic                   src_stall,
	input  rc4_pkg::rc4_in_t       src_data,
	output logic                   res_valid,
	input  logic                   res_stall,
	output rc4_pkg::rc4_out_t      res_data,
	input  logic                   cfg_we,
	input  logic [rc4_pkg::KLEN_W-1:0] cfg_wdata
);
	import rc4_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_INIT = 4'd1;
	localparam logic [3:0] ST_MRD  = 4'd2;
	localparam logic [3:0] ST_MJ   = 4'd3;
	localparam logic [3:0] ST_MWI  = 4'd4;
	localparam logic [3:0] ST_MWJ  = 4'd5;
	localparam logic [3:0] ST_CA   = 4'd6;
	localparam logic [3:0] ST_CB   = 4'd7;
	localparam logic [3:0] ST_CC   = 4'd8;
	localparam logic [3:0] ST_CD   = 4'd9;
	localparam logic [3:0] ST_CE   = 4'd10;
	localparam logic [3:0] ST_CF   = 4'd11;

	localparam logic [7:0] LAST_IDX = 8'd255;

	logic [3:0]        state_q;
	logic [7:0]        i_q;
	logic [7:0]        j_q;
	logic [KEY_AW-1:0] k_q;
	logic [7:0]        x_q;
	logic [7:0]        y_q;
	logic [7:0]        a_q;
	logic [7:0]        b_q;
	logic [7:0]        data_q;
	logic [KLEN_W-1:0] key_len_q;
	logic              res_valid_q;
	rc4_out_t          res_data_q;

	logic [7:0] perm_mem [256];
	logic [7:0] key_mem [KEY_DEPTH];
	logic [7:0] prd_q;
	logic [7:0] key_rd_q;

	logic              src_xfer;
	logic              pwe;
	logic [7:0]        paddr;
	logic [7:0]        pwdata;
	logic [7:0]        j_next;
	logic [KLEN_W-1:0] n_eff;
	logic [KLEN_W-1:0] k_inc;
	logic              key_we;
	logic              res_free;
	logic [7:0]        ks;

	assign src_stall = (state_q != ST_IDLE);
	assign src_xfer  = src_valid && !src_stall;
	assign res_valid = res_valid_q;
	assign res_data  = res_data_q;
	assign res_free  = !res_valid_q || !res_stall;
	assign ks        = prd_q;

	// one shared 8-bit adder chain for the key mix step
	assign j_next = j_q + prd_q + key_rd_q;

	always_comb begin
		if (key_len_q == '0) begin
			n_eff = KLEN_W'(1);
		end else if (key_len_q > KLEN_W'(KEY_DEPTH)) begin
			n_eff = KLEN_W'(KEY_DEPTH);
		end else begin
			n_eff = key_len_q;
		end
	end

	assign k_inc  = KLEN_W'(k_q) + KLEN_W'(1);
	assign key_we = src_xfer && (src_data.action == ACT_LOAD)
		&& ({1'b0, src_data.key_index} < KLEN_W'(KEY_DEPTH));

	// table RAM port select
	always_comb begin
		pwe    = 1'b0;
		paddr  = i_q;
		pwdata = i_q;
		case (state_q)
			ST_INIT: begin
				pwe = 1'b1;
			end
			ST_MRD: begin
				paddr = i_q;
			end
			ST_MJ: begin
				paddr = j_next;
			end
			ST_MWI: begin
				pwe    = 1'b1;
				paddr  = i_q;
				pwdata = prd_q;
			end
			ST_MWJ: begin
				pwe    = 1'b1;
				paddr  = j_q;
				pwdata = a_q;
			end
			ST_CA: begin
				paddr = x_q + 8'd1;
			end
			ST_CB: begin
				paddr = y_q + prd_q;
			end
			ST_CC: begin
				pwe    = 1'b1;
				paddr  = x_q;
				pwdata = prd_q;
			end
			ST_CD: begin
				pwe    = 1'b1;
				paddr  = y_q;
				pwdata = a_q;
			end
			// keep reading the keystream entry while the result waits
			ST_CE, ST_CF: begin
				paddr = a_q + b_q;
			end
			default: begin
				pwe = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pwe) begin
			perm_mem[paddr] <= pwdata;
		end else begin
			prd_q <= perm_mem[paddr];
		end
	end

	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[src_data.key_index[KEY_AW-1:0]] <= src_data.byte_value;
		end else begin
			key_rd_q <= key_mem[k_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_len_q <= KLEN_RESET;
		end else if (cfg_we) begin
			key_len_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (src_xfer) begin
			data_q <= src_data.byte_value;
		end
		case (state_q)
			ST_MJ: begin
				a_q <= prd_q;
			end
			ST_CB: begin
				a_q <= prd_q;
			end
			ST_CC: begin
				b_q <= prd_q;
			end
			default: begin
			end
		endcase
		if (state_q == ST_CF && res_free) begin
			res_data_q.out_byte       <= data_q ^ ks;
			res_data_q.keystream_byte <= ks;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			x_q         <= '0;
			y_q         <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && !res_stall && (state_q != ST_CF)) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (src_xfer) begin
						case (src_data.action)
							ACT_SCHED: begin
								i_q     <= '0;
								state_q <= ST_INIT;
							end
							ACT_CRYPT: begin
								state_q <= ST_CA;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_INIT: begin
					i_q <= i_q + 8'd1;
					if (i_q == LAST_IDX) begin
						j_q     <= '0;
						k_q     <= '0;
						state_q <= ST_MRD;
					end
				end
				ST_MRD: begin
					state_q <= ST_MJ;
				end
				ST_MJ: begin
					j_q     <= j_next;
					state_q <= ST_MWI;
				end
				ST_MWI: begin
					state_q <= ST_MWJ;
				end
				ST_MWJ: begin
					i_q <= i_q + 8'd1;
					if (k_inc >= n_eff) begin
						k_q <= '0;
					end else begin
						k_q <= k_inc[KEY_AW-1:0];
					end
					if (i_q == LAST_IDX) begin
						x_q     <= '0;
						y_q     <= '0;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_MRD;
					end
				end
				ST_CA: begin
					x_q     <= x_q + 8'd1;
					state_q <= ST_CB;
				end
				ST_CB: begin
					y_q     <= y_q + prd_q;
					state_q <= ST_CC;
				end
				ST_CC: begin
					state_q <= ST_CD;
				end
				ST_CD: begin
					state_q <= ST_CE;
				end
				ST_CE: begin
					state_q <= ST_CF;
				end
				ST_CF: begin
					if (res_free) begin
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// a crypt transfer starts the keystream step right away
	a_crypt_start: assert property (@(posedge clk) disable iff (!arst_n)
		src_xfer && (src_data.action == ACT_CRYPT) |=> state_q == ST_CA)
		else $error("crypt transfer did not start keystream step");

	// end of the key mix leaves both keystream indices at zero
	a_sched_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MWJ) && (i_q == LAST_IDX) |=> (x_q == '0) && (y_q == '0)
			&& (state_q == ST_IDLE))
		else $error("key schedule end did not clear indices");

	// key position always stays inside the effective key length while mixing
	a_key_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MRD) || (state_q == ST_MJ) |-> KLEN_W'(k_q) < n_eff)
		else $error("key position beyond key length");

	// a result is loaded only when the output register is free
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_stall && (state_q == ST_CF) |=> state_q == ST_CF)
		else $error("result left last step while output was held");

endmodule
